FILE: sv/accel_calibrate_fir_deadband_duty_assert.svh
// Assertion macros for the calibrate, FIR and dead-band duty block
`ifndef ACCEL_CALIBRATE_FIR_DEADBAND_DUTY_ASSERT_SVH
`define ACCEL_CALIBRATE_FIR_DEADBAND_DUTY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock, off during reset
`define CDF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset
`define CDF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CDF_ASSERT_SAME(lbl, ante, cons, msg)
`define CDF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/cdf_pkg.sv
// Shared constants, types and register codes for the calibrate/FIR/duty block
package cdf_pkg;

   localparam int TAPS       = 5;
   localparam int WARMUP     = 4;
   localparam int WARM_W     = 3;
   localparam int NDELAY     = TAPS - 1;
   localparam int NPROD      = (TAPS + 1) / 2;

   localparam int ACC_W      = 16;
   localparam int OFF_W      = 16;
   localparam int TAP_W      = 15;
   localparam int TARGET_W   = 8;
   localparam int FILT_W     = 20;
   localparam int DUTY_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int OFFSET_RST     = 6;
   localparam int TAP_OUTER_RST  = 3277;
   localparam int TAP_INNER_RST  = 4915;
   localparam int TAP_CENTER_RST = 16384;

   // 0.846 as 55443 / 2^16, result in sixteenths: shift by 12 with half-up rounding
   localparam int CAL_GAIN   = 55443;
   localparam int CAL_PROD_W = ACC_W + 17;
   localparam int CAL_SHIFT  = 12;
   localparam int CAL_ROUND  = 1 << (CAL_SHIFT - 1);

   localparam int PROD_W     = FILT_W + 1 + TAP_W + 1;
   localparam int SUM_W      = PROD_W + $clog2(NPROD) + 1;
   localparam int FIR_SHIFT  = 15;
   localparam int FIR_ROUND  = 1 << (FIR_SHIFT - 1);
   localparam int FILT_MAX   = (1 << (FILT_W - 1)) - 1;
   localparam int FILT_MIN   = -(1 << (FILT_W - 1));

   // duty = |filt*100 - (target-90)*15696| / 15696
   localparam int DUTY_PCT    = 100;
   localparam int DUTY_DIV    = 15696;
   localparam int TARGET_BIAS = 90;
   localparam int DEAD_BAND   = 5;
   localparam int DUTY_MAX    = 101;
   localparam int DIFF_W      = 28;
   localparam int BIAS_W      = TARGET_W + 2;
   localparam int DQ_W        = $clog2((DUTY_MAX + 1) * DUTY_DIV);
   // ceil(2^35 / 15696); exact floor for every operand below DQ_W bits
   localparam int DUTY_RECIP  = 2189077;
   localparam int RECIP_W     = 22;
   localparam int DUTY_SHIFT  = 35;
   localparam int QPROD_W     = DQ_W + RECIP_W;

   typedef logic signed [CAL_PROD_W-1:0] cal_prod_type;
   typedef logic signed [FILT_W-1:0]     filt_type;
   typedef logic signed [FILT_W:0]       pair_type;
   typedef logic signed [TAP_W:0]        wgt_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [BIAS_W-1:0]     bias_type;
   typedef logic [DQ_W-1:0]              dq_type;
   typedef logic [QPROD_W-1:0]           qprod_type;
   typedef logic [DUTY_W-1:0]            duty_type;
   typedef logic [WARM_W-1:0]            warm_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X     = 3'd0,
      CSR_OFFSET_Y     = 3'd1,
      CSR_OFFSET_Z     = 3'd2,
      CSR_TAP_OUTER    = 3'd3,
      CSR_TAP_INNER    = 3'd4,
      CSR_TAP_CENTER   = 3'd5,
      CSR_ROLL_TARGET  = 3'd6,
      CSR_PITCH_TARGET = 3'd7
   } csr_index_type;

   // per-stage load strobes of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic shift;
   } stage_en_type;

endpackage

FILE: sv/accel_calibrate_fir_deadband_duty.sv
// Top level: three-axis calibration and FIR lanes, tilt duty, handshake and registers
// A result passes the stage 1 to 4 registers and the output register once accepted.
// Throughput: one transaction per cycle unless rsp_stall backs up the five-stage
// pipeline; a per-stage ready chain sets this, three axis lanes, two duty units in parallel.
// The first four transactions after reset are absorbed and give no result.
// Synchronous reset: registers to defaults, delay lines zeroed, pipeline emptied.
`include "accel_calibrate_fir_deadband_duty_assert.svh"

module accel_calibrate_fir_deadband_duty (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cdf_pkg::ACC_W-1:0]       req_acc_x,
   input  logic signed [cdf_pkg::ACC_W-1:0]       req_acc_y,
   input  logic signed [cdf_pkg::ACC_W-1:0]       req_acc_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cdf_pkg::FILT_W-1:0]      rsp_filt_x,
   output logic signed [cdf_pkg::FILT_W-1:0]      rsp_filt_y,
   output logic signed [cdf_pkg::FILT_W-1:0]      rsp_filt_z,
   output logic [cdf_pkg::DUTY_W-1:0]             rsp_roll_duty,
   output logic                                   rsp_roll_update,
   output logic [cdf_pkg::DUTY_W-1:0]             rsp_pitch_duty,
   output logic                                   rsp_pitch_update,
   input  logic                                   csr_we,
   input  logic [cdf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [cdf_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   logic signed [cdf_pkg::OFF_W-1:0] offset_x_ff, offset_x_in;
   logic signed [cdf_pkg::OFF_W-1:0] offset_y_ff, offset_y_in;
   logic signed [cdf_pkg::OFF_W-1:0] offset_z_ff, offset_z_in;
   logic [cdf_pkg::TAP_W-1:0]        tap_outer_ff, tap_outer_in;
   logic [cdf_pkg::TAP_W-1:0]        tap_inner_ff, tap_inner_in;
   logic [cdf_pkg::TAP_W-1:0]        tap_center_ff, tap_center_in;
   logic [cdf_pkg::TARGET_W-1:0]     roll_target_ff, roll_target_in;
   logic [cdf_pkg::TARGET_W-1:0]     pitch_target_ff, pitch_target_in;

   cdf_pkg::warm_type     warm_ff, warm_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic                  s2_vld_ff, s2_vld_in;
   logic                  s3_vld_ff, s3_vld_in;
   logic                  s4_vld_ff, s4_vld_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  rdy1, rdy2, rdy3, rdy4, rdy5;
   logic                  take;
   cdf_pkg::stage_en_type en;

   cdf_pkg::filt_type     lane_x, lane_y, lane_z;
   cdf_pkg::filt_type     filt4_x_ff, filt4_y_ff, filt4_z_ff;
   cdf_pkg::duty_type     roll_duty, pitch_duty;
   logic                  roll_upd, pitch_upd;

   cdf_pkg::filt_type     rsp_filt_x_ff, rsp_filt_y_ff, rsp_filt_z_ff;
   cdf_pkg::duty_type     rsp_roll_duty_ff, rsp_pitch_duty_ff;
   logic                  rsp_roll_update_ff, rsp_pitch_update_ff;

   // register file
   always_comb begin
      offset_x_in     = offset_x_ff;
      offset_y_in     = offset_y_ff;
      offset_z_in     = offset_z_ff;
      tap_outer_in    = tap_outer_ff;
      tap_inner_in    = tap_inner_ff;
      tap_center_in   = tap_center_ff;
      roll_target_in  = roll_target_ff;
      pitch_target_in = pitch_target_ff;
      if (csr_we) begin
         case (cdf_pkg::csr_index_type'(csr_index))
            cdf_pkg::CSR_OFFSET_X:     offset_x_in     = $signed(csr_wdata);
            cdf_pkg::CSR_OFFSET_Y:     offset_y_in     = $signed(csr_wdata);
            cdf_pkg::CSR_OFFSET_Z:     offset_z_in     = $signed(csr_wdata);
            cdf_pkg::CSR_TAP_OUTER:    tap_outer_in    = csr_wdata[cdf_pkg::TAP_W-1:0];
            cdf_pkg::CSR_TAP_INNER:    tap_inner_in    = csr_wdata[cdf_pkg::TAP_W-1:0];
            cdf_pkg::CSR_TAP_CENTER:   tap_center_in   = csr_wdata[cdf_pkg::TAP_W-1:0];
            cdf_pkg::CSR_ROLL_TARGET:  roll_target_in  = csr_wdata[cdf_pkg::TARGET_W-1:0];
            cdf_pkg::CSR_PITCH_TARGET: pitch_target_in = csr_wdata[cdf_pkg::TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff     <= cdf_pkg::OFF_W'(cdf_pkg::OFFSET_RST);
         offset_y_ff     <= cdf_pkg::OFF_W'(cdf_pkg::OFFSET_RST);
         offset_z_ff     <= cdf_pkg::OFF_W'(cdf_pkg::OFFSET_RST);
         tap_outer_ff    <= cdf_pkg::TAP_W'(cdf_pkg::TAP_OUTER_RST);
         tap_inner_ff    <= cdf_pkg::TAP_W'(cdf_pkg::TAP_INNER_RST);
         tap_center_ff   <= cdf_pkg::TAP_W'(cdf_pkg::TAP_CENTER_RST);
         roll_target_ff  <= '0;
         pitch_target_ff <= '0;
      end else begin
         offset_x_ff     <= offset_x_in;
         offset_y_ff     <= offset_y_in;
         offset_z_ff     <= offset_z_in;
         tap_outer_ff    <= tap_outer_in;
         tap_inner_ff    <= tap_inner_in;
         tap_center_ff   <= tap_center_in;
         roll_target_ff  <= roll_target_in;
         pitch_target_ff <= pitch_target_in;
      end
   end

   // pipeline flow control
   always_comb begin
      rdy5      = !rsp_vld_ff || !rsp_stall;
      rdy4      = !s4_vld_ff || rdy5;
      rdy3      = !s3_vld_ff || rdy4;
      rdy2      = !s2_vld_ff || rdy3;
      rdy1      = !s1_vld_ff || rdy2;
      req_stall = !rdy1;
      take      = req_valid && rdy1 && (warm_ff == '0);

      warm_in = warm_ff;
      if (req_valid && rdy1 && (warm_ff != '0)) begin
         warm_in = warm_ff - 1'b1;
      end

      s1_vld_in  = rdy1 ? take      : s1_vld_ff;
      s2_vld_in  = rdy2 ? s1_vld_ff : s2_vld_ff;
      s3_vld_in  = rdy3 ? s2_vld_ff : s3_vld_ff;
      s4_vld_in  = rdy4 ? s3_vld_ff : s4_vld_ff;
      rsp_vld_in = rdy5 ? s4_vld_ff : rsp_vld_ff;

      en.s1    = rdy1;
      en.s2    = rdy2;
      en.s3    = rdy3;
      en.s4    = rdy4;
      en.shift = rdy2 && s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff    <= cdf_pkg::warm_type'(cdf_pkg::WARMUP);
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         warm_ff    <= warm_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   cdf_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .acc        (req_acc_x),
      .offset     (offset_x_ff),
      .tap_outer  (tap_outer_ff),
      .tap_inner  (tap_inner_ff),
      .tap_center (tap_center_ff),
      .filt       (lane_x)
   );

   cdf_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .acc        (req_acc_y),
      .offset     (offset_y_ff),
      .tap_outer  (tap_outer_ff),
      .tap_inner  (tap_inner_ff),
      .tap_center (tap_center_ff),
      .filt       (lane_y)
   );

   cdf_lane u_lane_z (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .acc        (req_acc_z),
      .offset     (offset_z_ff),
      .tap_outer  (tap_outer_ff),
      .tap_inner  (tap_inner_ff),
      .tap_center (tap_center_ff),
      .filt       (lane_z)
   );

   cdf_duty u_duty_roll (
      .clock  (clock),
      .en     (en),
      .filt   (lane_x),
      .target (roll_target_ff),
      .duty   (roll_duty),
      .update (roll_upd)
   );

   cdf_duty u_duty_pitch (
      .clock  (clock),
      .en     (en),
      .filt   (lane_y),
      .target (pitch_target_ff),
      .duty   (pitch_duty),
      .update (pitch_upd)
   );

   // merge: align filtered axes with the duty results, then output register
   always_ff @(posedge clock) begin
      if (rdy4) begin
         filt4_x_ff <= lane_x;
         filt4_y_ff <= lane_y;
         filt4_z_ff <= lane_z;
      end
      if (rdy5) begin
         rsp_filt_x_ff       <= filt4_x_ff;
         rsp_filt_y_ff       <= filt4_y_ff;
         rsp_filt_z_ff       <= filt4_z_ff;
         rsp_roll_duty_ff    <= roll_duty;
         rsp_roll_update_ff  <= roll_upd;
         rsp_pitch_duty_ff   <= pitch_duty;
         rsp_pitch_update_ff <= pitch_upd;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_filt_x       = rsp_filt_x_ff;
   assign rsp_filt_y       = rsp_filt_y_ff;
   assign rsp_filt_z       = rsp_filt_z_ff;
   assign rsp_roll_duty    = rsp_roll_duty_ff;
   assign rsp_roll_update  = rsp_roll_update_ff;
   assign rsp_pitch_duty   = rsp_pitch_duty_ff;
   assign rsp_pitch_update = rsp_pitch_update_ff;

   `CDF_ASSERT_SAME(a_rsp_after_warmup, rsp_vld_ff, warm_ff == '0, "result during warmup")
   `CDF_ASSERT_NEXT(a_accept_enters, take, s1_vld_ff, "accepted transaction lost at entry")
   `CDF_ASSERT_SAME(a_roll_range, rsp_vld_ff, rsp_roll_duty_ff <= cdf_pkg::duty_type'(cdf_pkg::DUTY_MAX), "roll duty out of range")
   `CDF_ASSERT_SAME(a_roll_off_zero, rsp_vld_ff && !rsp_roll_update_ff, rsp_roll_duty_ff == '0, "roll duty set while disabled")
   `CDF_ASSERT_SAME(a_pitch_off_zero, rsp_vld_ff && !rsp_pitch_update_ff, rsp_pitch_duty_ff == '0, "pitch duty set while disabled")

endmodule

FILE: sv/cdf_lane.sv
// One axis lane: calibration multiply, symmetric FIR products and rounded sum
module cdf_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  cdf_pkg::stage_en_type               en,
   input  logic signed [cdf_pkg::ACC_W-1:0]    acc,
   input  logic signed [cdf_pkg::OFF_W-1:0]    offset,
   input  logic [cdf_pkg::TAP_W-1:0]           tap_outer,
   input  logic [cdf_pkg::TAP_W-1:0]           tap_inner,
   input  logic [cdf_pkg::TAP_W-1:0]           tap_center,
   output logic signed [cdf_pkg::FILT_W-1:0]   filt
);

   cdf_pkg::cal_prod_type gain_ff, gain_in;
   cdf_pkg::cal_prod_type cal_round;
   cdf_pkg::pair_type     cal_wide;
   cdf_pkg::filt_type     cal;
   cdf_pkg::filt_type     smp [cdf_pkg::TAPS];
   cdf_pkg::pair_type     pair_sum [cdf_pkg::NPROD];
   cdf_pkg::wgt_type      wgt [cdf_pkg::NPROD];
   cdf_pkg::prod_type     prod_ff [cdf_pkg::NPROD];
   cdf_pkg::prod_type     prod_in [cdf_pkg::NPROD];
   cdf_pkg::filt_type     dly_ff [cdf_pkg::NDELAY];
   cdf_pkg::filt_type     dly_in [cdf_pkg::NDELAY];
   cdf_pkg::sum_type      acc_sum, acc_rnd;
   cdf_pkg::filt_type     filt_ff, filt_in;

   // stage 1: gain product
   always_comb begin
      gain_in = cdf_pkg::cal_prod_type'(acc) * cdf_pkg::cal_prod_type'(cdf_pkg::CAL_GAIN);
   end

   // stage 2: round, offset, pre-add symmetric pairs, weight
   always_comb begin
      cal_round = gain_ff + cdf_pkg::cal_prod_type'(cdf_pkg::CAL_ROUND);
      cal_wide  = cdf_pkg::pair_type'(cal_round >>> cdf_pkg::CAL_SHIFT)
                  + cdf_pkg::pair_type'(offset);
      cal       = cdf_pkg::filt_type'(cal_wide);

      smp[0] = cal;
      for (int i = 1; i < cdf_pkg::TAPS; i++) begin
         smp[i] = dly_ff[i-1];
      end

      dly_in[0] = cal;
      for (int i = 1; i < cdf_pkg::NDELAY; i++) begin
         dly_in[i] = dly_ff[i-1];
      end

      for (int k = 0; k < cdf_pkg::NPROD; k++) begin
         if (2 * k + 1 == cdf_pkg::TAPS) begin
            pair_sum[k] = cdf_pkg::pair_type'(smp[k]);
            wgt[k]      = cdf_pkg::wgt_type'({1'b0, tap_center});
         end else begin
            pair_sum[k] = cdf_pkg::pair_type'(smp[k])
                          + cdf_pkg::pair_type'(smp[cdf_pkg::TAPS-1-k]);
            wgt[k]      = (k == 0) ? cdf_pkg::wgt_type'({1'b0, tap_outer})
                                   : cdf_pkg::wgt_type'({1'b0, tap_inner});
         end
         prod_in[k] = cdf_pkg::prod_type'(pair_sum[k]) * cdf_pkg::prod_type'(wgt[k]);
      end
   end

   // stage 3: sum, round half up, saturate
   always_comb begin
      acc_sum = '0;
      for (int k = 0; k < cdf_pkg::NPROD; k++) begin
         acc_sum = acc_sum + cdf_pkg::sum_type'(prod_ff[k]);
      end
      acc_rnd = (acc_sum + cdf_pkg::sum_type'(cdf_pkg::FIR_ROUND)) >>> cdf_pkg::FIR_SHIFT;
      if (acc_rnd > cdf_pkg::sum_type'(cdf_pkg::FILT_MAX)) begin
         filt_in = cdf_pkg::filt_type'(cdf_pkg::FILT_MAX);
      end else if (acc_rnd < cdf_pkg::sum_type'(cdf_pkg::FILT_MIN)) begin
         filt_in = cdf_pkg::filt_type'(cdf_pkg::FILT_MIN);
      end else begin
         filt_in = cdf_pkg::filt_type'(acc_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         gain_ff <= gain_in;
      end
      if (en.s2) begin
         prod_ff <= prod_in;
      end
      if (en.s3) begin
         filt_ff <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdf_pkg::NDELAY; i++) begin
            dly_ff[i] <= '0;
         end
      end else if (en.shift) begin
         dly_ff <= dly_in;
      end
   end

   assign filt = filt_ff;

endmodule

FILE: sv/cdf_duty.sv
// Dead-band duty for one tilt axis: distance from target, band check, divide, clamp
module cdf_duty (
   input  logic                                clock,
   input  cdf_pkg::stage_en_type               en,
   input  logic signed [cdf_pkg::FILT_W-1:0]   filt,
   input  logic [cdf_pkg::TARGET_W-1:0]        target,
   output logic [cdf_pkg::DUTY_W-1:0]          duty,
   output logic                                update
);

   cdf_pkg::diff_type  scaled, diff, mag;
   cdf_pkg::bias_type  bias;
   cdf_pkg::dq_type    dq_ff, dq_in;
   logic               dead_ff, dead_in;
   logic               big_ff, big_in;
   logic               on_ff, on_in;
   cdf_pkg::qprod_type qprod;
   cdf_pkg::duty_type  quot;

   always_comb begin
      scaled  = cdf_pkg::diff_type'(filt) * cdf_pkg::diff_type'(cdf_pkg::DUTY_PCT);
      bias    = cdf_pkg::bias_type'({2'b00, target})
                - cdf_pkg::bias_type'(cdf_pkg::TARGET_BIAS);
      diff    = scaled - cdf_pkg::diff_type'(bias) * cdf_pkg::diff_type'(cdf_pkg::DUTY_DIV);
      mag     = diff[cdf_pkg::DIFF_W-1] ? -diff : diff;
      dead_in = mag < cdf_pkg::diff_type'(cdf_pkg::DEAD_BAND * cdf_pkg::DUTY_DIV);
      big_in  = mag >= cdf_pkg::diff_type'((cdf_pkg::DUTY_MAX + 1) * cdf_pkg::DUTY_DIV);
      dq_in   = big_in ? '0 : cdf_pkg::dq_type'(mag);
      on_in   = target != '0;
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         dq_ff   <= dq_in;
         dead_ff <= dead_in;
         big_ff  <= big_in;
         on_ff   <= on_in;
      end
   end

   // divide by 15696 as multiply by reciprocal
   always_comb begin
      qprod = cdf_pkg::qprod_type'(dq_ff) * cdf_pkg::qprod_type'(cdf_pkg::DUTY_RECIP);
      quot  = qprod[cdf_pkg::DUTY_SHIFT +: cdf_pkg::DUTY_W];
      if (!on_ff || dead_ff) begin
         duty = '0;
      end else if (big_ff) begin
         duty = cdf_pkg::duty_type'(cdf_pkg::DUTY_MAX);
      end else begin
         duty = quot;
      end
   end

   assign update = on_ff;

endmodule

FILE: bench/accel_calibrate_fir_deadband_duty_test.sv
// Self-checking testbench for the accelerometer calibrate, FIR and tilt duty block
module accel_calibrate_fir_deadband_duty_test;

   typedef logic signed [cdf_pkg::ACC_W-1:0] acc_type;
   typedef logic [cdf_pkg::CSR_DATA_W-1:0] reg_word_type;
   typedef reg_word_type reg_image_type [8];

   typedef struct packed {
      cdf_pkg::filt_type filt_x;
      cdf_pkg::filt_type filt_y;
      cdf_pkg::filt_type filt_z;
      cdf_pkg::duty_type roll_duty;
      logic              roll_update;
      cdf_pkg::duty_type pitch_duty;
      logic              pitch_update;
   } tilt_rsp_type;

   typedef struct packed {
      int           ax;
      int           ay;
      int           az;
      bit           typed;
      bit           has_rsp;
      tilt_rsp_type rsp;
   } probe_row_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   localparam int     NUM_TAPS      = 5;
   localparam int     WARM_COUNT    = 4;
   localparam longint GAIN          = 55443;
   localparam longint GAIN_ROUND    = 2048;
   localparam int     GAIN_SHIFT    = 12;
   localparam longint FIR_RND       = 16384;
   localparam int     FIR_SH        = 15;
   localparam longint FILT_HI       = 524287;
   localparam longint FILT_LO       = -524288;
   localparam longint G_SIXTEENTHS  = 15696;
   localparam longint LEVEL_DEG     = 90;
   localparam longint DEAD_ZONE     = 5;
   localparam longint DUTY_TOP      = 101;
   localparam int     SETTLE_CYCLES = 10;
   localparam int     PROBE_A_N     = 11;
   localparam int     PROBE_B_N     = 12;
   localparam int     RANDOM_PHASES = 6;
   localparam int     PHASE_ITEMS   = 95;

   localparam tilt_rsp_type RSP_NONE = '0;
   localparam tilt_rsp_type RSP_ONE  = '{20'sd1, 20'sd1, 20'sd1, 7'd0, 1'b0, 7'd0, 1'b0};
   localparam tilt_rsp_type RSP_TWO  = '{20'sd2, 20'sd2, 20'sd2, 7'd0, 1'b0, 7'd0, 1'b0};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   acc_type           req_acc_x = '0;
   acc_type           req_acc_y = '0;
   acc_type           req_acc_z = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cdf_pkg::filt_type rsp_filt_x;
   cdf_pkg::filt_type rsp_filt_y;
   cdf_pkg::filt_type rsp_filt_z;
   cdf_pkg::duty_type rsp_roll_duty;
   logic              rsp_roll_update;
   cdf_pkg::duty_type rsp_pitch_duty;
   logic              rsp_pitch_update;
   logic              csr_we = 1'b0;
   logic [cdf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   reg_word_type      csr_wdata = '0;

   accel_calibrate_fir_deadband_duty u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_acc_x        (req_acc_x),
      .req_acc_y        (req_acc_y),
      .req_acc_z        (req_acc_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filt_x       (rsp_filt_x),
      .rsp_filt_y       (rsp_filt_y),
      .rsp_filt_z       (rsp_filt_z),
      .rsp_roll_duty    (rsp_roll_duty),
      .rsp_roll_update  (rsp_roll_update),
      .rsp_pitch_duty   (rsp_pitch_duty),
      .rsp_pitch_update (rsp_pitch_update),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // tilt predictor state
   longint cal_offset [3];
   longint tap_outer, tap_inner, tap_center;
   longint roll_target, pitch_target;
   int     warm_left;
   longint delay_line [3][NUM_TAPS-1];

   tilt_rsp_type   pending_tilt [$];
   tilt_rsp_type   seen_rsp, want_rsp;
   int             mismatch_count = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_phase = 0;
   probe_row_type  probe_a [PROBE_A_N];
   probe_row_type  probe_b [PROBE_B_N];

   always #10 clock = ~clock;

   function automatic longint clamp_filt(input longint v);
      if (v > FILT_HI) return FILT_HI;
      if (v < FILT_LO) return FILT_LO;
      return v;
   endfunction

   function automatic longint tap_weight(input int i);
      if (i == 0 || i == NUM_TAPS - 1) return tap_outer;
      if ((NUM_TAPS % 2) == 1 && i == NUM_TAPS / 2) return tap_center;
      return tap_inner;
   endfunction

   function automatic cdf_pkg::duty_type tilt_duty(input longint filt, input longint target);
      longint d;
      d = filt * 100 - (target - LEVEL_DEG) * G_SIXTEENTHS;
      if (d < 0) d = -d;
      if (d < DEAD_ZONE * G_SIXTEENTHS) return '0;
      d = d / G_SIXTEENTHS;
      if (d > DUTY_TOP) d = DUTY_TOP;
      return cdf_pkg::duty_type'(d);
   endfunction

   function automatic bit predict_tilt(input int ax, input int ay, input int az,
                                       output tilt_rsp_type r);
      longint raw [3];
      longint filt [3];
      longint cal, acc;
      int a, i;
      r = '0;
      if (warm_left != 0) begin
         warm_left--;
         return 1'b0;
      end
      raw[0] = longint'(acc_type'(ax));
      raw[1] = longint'(acc_type'(ay));
      raw[2] = longint'(acc_type'(az));
      for (a = 0; a < 3; a++) begin
         cal = ((raw[a] * GAIN + GAIN_ROUND) >>> GAIN_SHIFT) + cal_offset[a];
         acc = tap_weight(0) * cal;
         for (i = 1; i < NUM_TAPS; i++) acc += tap_weight(i) * delay_line[a][i-1];
         for (i = NUM_TAPS - 2; i > 0; i--) delay_line[a][i] = delay_line[a][i-1];
         delay_line[a][0] = clamp_filt(cal);
         filt[a] = clamp_filt((acc + FIR_RND) >>> FIR_SH);
      end
      r.filt_x       = cdf_pkg::filt_type'(filt[0]);
      r.filt_y       = cdf_pkg::filt_type'(filt[1]);
      r.filt_z       = cdf_pkg::filt_type'(filt[2]);
      r.roll_update  = (roll_target != 0);
      r.roll_duty    = (roll_target != 0) ? tilt_duty(filt[0], roll_target) : '0;
      r.pitch_update = (pitch_target != 0);
      r.pitch_duty   = (pitch_target != 0) ? tilt_duty(filt[1], pitch_target) : '0;
      return 1'b1;
   endfunction

   // called at a falling edge; leaves the write enable high for the caller to drop
   task automatic write_reg(input cdf_pkg::csr_index_type idx, input reg_word_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         cdf_pkg::CSR_OFFSET_X:     cal_offset[0] = longint'($signed(val));
         cdf_pkg::CSR_OFFSET_Y:     cal_offset[1] = longint'($signed(val));
         cdf_pkg::CSR_OFFSET_Z:     cal_offset[2] = longint'($signed(val));
         cdf_pkg::CSR_TAP_OUTER:    tap_outer = longint'(val[14:0]);
         cdf_pkg::CSR_TAP_INNER:    tap_inner = longint'(val[14:0]);
         cdf_pkg::CSR_TAP_CENTER:   tap_center = longint'(val[14:0]);
         cdf_pkg::CSR_ROLL_TARGET:  roll_target = longint'(val[7:0]);
         cdf_pkg::CSR_PITCH_TARGET: pitch_target = longint'(val[7:0]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input reg_image_type img);
      int i;
      for (i = 0; i < 8; i++) write_reg(cdf_pkg::csr_index_type'(i), img[i]);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input int ax, input int ay, input int az, input bit typed,
                              input bit typed_has, input tilt_rsp_type typed_rsp);
      tilt_rsp_type r;
      bit got;
      req_valid <= 1'b1;
      req_acc_x <= acc_type'(ax);
      req_acc_y <= acc_type'(ay);
      req_acc_z <= acc_type'(az);
      do @(posedge clock); while (req_stall);
      got = predict_tilt(ax, ay, az, r);
      if (typed) begin
         got = typed_has;
         r   = typed_rsp;
      end
      if (got) pending_tilt.push_back(r);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 12 : 3)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48)
                                                  : $urandom_range(0, 4);
      end
   endtask

   task automatic drain_pipeline;
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      while (pending_tilt.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_random_phase(input int count);
      int base [3];
      int v [3];
      int hold, n, a, mode;
      hold = 0;
      for (n = 0; n < count; n++) begin
         if (hold == 0) begin
            for (a = 0; a < 3; a++) base[a] = int'($urandom_range(0, 2200)) - 1100;
            hold = $urandom_range(6, 30);
         end
         hold--;
         mode = $urandom_range(0, 19);
         for (a = 0; a < 3; a++) begin
            if (mode < 15) begin
               v[a] = base[a] + int'($urandom_range(0, 60)) - 30;
            end else if (mode < 18) begin
               v[a] = int'($urandom_range(0, 65535)) - 32768;
            end else begin
               case ($urandom_range(0, 3))
                  0: v[a] = 32767;
                  1: v[a] = -32768;
                  2: v[a] = 0;
                  default: v[a] = -1;
               endcase
            end
         end
         send_sample(v[0], v[1], v[2], 1'b0, 1'b0, RSP_NONE);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_phase % 3 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_rsp = {rsp_filt_x, rsp_filt_y, rsp_filt_z, rsp_roll_duty, rsp_roll_update,
                     rsp_pitch_duty, rsp_pitch_update};
         if (pending_tilt.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: filt %0d %0d %0d roll %0d/%0d pitch %0d/%0d",
                        seen_rsp.filt_x, seen_rsp.filt_y, seen_rsp.filt_z, seen_rsp.roll_duty,
                        seen_rsp.roll_update, seen_rsp.pitch_duty, seen_rsp.pitch_update);
         end else begin
            want_rsp = pending_tilt.pop_front();
            if (seen_rsp !== want_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp filt %0d %0d %0d roll %0d/%0d pitch %0d/%0d,",
                            " got %0d %0d %0d roll %0d/%0d pitch %0d/%0d"},
                           want_rsp.filt_x, want_rsp.filt_y, want_rsp.filt_z,
                           want_rsp.roll_duty, want_rsp.roll_update,
                           want_rsp.pitch_duty, want_rsp.pitch_update,
                           seen_rsp.filt_x, seen_rsp.filt_y, seen_rsp.filt_z,
                           seen_rsp.roll_duty, seen_rsp.roll_update,
                           seen_rsp.pitch_duty, seen_rsp.pitch_update);
            end
         end
      end
   end

   initial begin
      #(20 * 400000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reg_image_type img;
      int i, p;
      cal_offset[0] = 6;
      cal_offset[1] = 6;
      cal_offset[2] = 6;
      tap_outer     = 3277;
      tap_inner     = 4915;
      tap_center    = 16384;
      roll_target   = 0;
      pitch_target  = 0;
      warm_left     = WARM_COUNT;
      for (i = 0; i < NUM_TAPS - 1; i++) begin
         delay_line[0][i] = 0;
         delay_line[1][i] = 0;
         delay_line[2][i] = 0;
      end

      // reset defaults, duty disabled; warmup transactions must not reach the delay lines
      probe_a = '{
         '{32767, -32768, 0, 1'b1, 1'b0, RSP_NONE},
         '{-32768, 32767, -1, 1'b1, 1'b0, RSP_NONE},
         '{-1, 0, 32767, 1'b1, 1'b0, RSP_NONE},
         '{12345, -12345, -32768, 1'b1, 1'b0, RSP_NONE},
         '{0, 0, 0, 1'b1, 1'b1, RSP_ONE},
         '{0, 0, 0, 1'b1, 1'b1, RSP_TWO},
         '{32767, 32767, 32767, 1'b0, 1'b0, RSP_NONE},
         '{-32768, -32768, -32768, 1'b0, 1'b0, RSP_NONE},
         '{32767, -32768, -1, 1'b0, 1'b0, RSP_NONE},
         '{1, -1, 1000, 1'b0, 1'b0, RSP_NONE},
         '{0, 0, 0, 1'b0, 1'b0, RSP_NONE}
      };
      // roll level, pitch at full target: dead band, mid range and saturation
      probe_b = '{
         '{0, 0, 1000, 1'b0, 1'b0, RSP_NONE},
         '{0, 0, 1000, 1'b0, 1'b0, RSP_NONE},
         '{1000, -1000, 0, 1'b0, 1'b0, RSP_NONE},
         '{1000, -1000, 0, 1'b0, 1'b0, RSP_NONE},
         '{1000, -1000, 0, 1'b0, 1'b0, RSP_NONE},
         '{32767, 32767, 0, 1'b0, 1'b0, RSP_NONE},
         '{32767, 32767, 0, 1'b0, 1'b0, RSP_NONE},
         '{-32768, -32768, 0, 1'b0, 1'b0, RSP_NONE},
         '{-32768, -32768, 0, 1'b0, 1'b0, RSP_NONE},
         '{58, 58, 0, 1'b0, 1'b0, RSP_NONE},
         '{58, 58, 0, 1'b0, 1'b0, RSP_NONE},
         '{-58, 1000, 0, 1'b0, 1'b0, RSP_NONE}
      };

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < PROBE_A_N; i++)
         send_sample(probe_a[i].ax, probe_a[i].ay, probe_a[i].az, probe_a[i].typed,
                     probe_a[i].has_rsp, probe_a[i].rsp);
      drain_pipeline();
      write_reg(cdf_pkg::CSR_ROLL_TARGET, 16'd90);
      write_reg(cdf_pkg::CSR_PITCH_TARGET, 16'd180);
      csr_we <= 1'b0;
      for (i = 0; i < PROBE_B_N; i++)
         send_sample(probe_b[i].ax, probe_b[i].ay, probe_b[i].az, probe_b[i].typed,
                     probe_b[i].has_rsp, probe_b[i].rsp);
      drain_pipeline();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: img = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'h0001, 16'h00FF};
            1: img = '{16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                       16'h00B4, 16'h0000};
            default: begin
               for (i = 0; i < 3; i++)
                  img[i] = ($urandom_range(0, 3) == 0)
                           ? reg_word_type'($urandom_range(0, 65535))
                           : reg_word_type'(int'($urandom_range(0, 400)) - 200);
               for (i = 3; i < 6; i++)
                  img[i] = ($urandom_range(0, 3) == 0)
                           ? reg_word_type'($urandom_range(0, 65535))
                           : reg_word_type'($urandom_range(2000, 18000));
               for (i = 6; i < 8; i++) begin
                  case ($urandom_range(0, 5))
                     0: img[i] = '0;
                     1: img[i] = reg_word_type'($urandom_range(181, 255));
                     default: img[i] = reg_word_type'($urandom_range(1, 180))
                                       | reg_word_type'($urandom_range(0, 255) << 8);
                  endcase
               end
            end
         endcase
         apply_settings(img);
         run_random_phase(PHASE_ITEMS);
         drain_pipeline();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += pending_tilt.size();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
